// File: hdl/aes_round_primitive_unit_defines.svh
// Assertion helpers
`ifndef AES_ROUND_PRIMITIVE_UNIT_DEFINES_SVH
`define AES_ROUND_PRIMITIVE_UNIT_DEFINES_SVH
`define ARP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("lbl");
`define ARP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("lbl");
`endif

// File: hdl/arpu_pkg.sv
package arpu_pkg;
  typedef enum logic [2:0] {
    OP_SUB = 3'd0, OP_SHIFT = 3'd1, OP_MIX = 3'd2, OP_ADDKEY = 3'd3,
    OP_INVSUB = 3'd4, OP_INVSHIFT = 3'd5, OP_INVMIX = 3'd6, OP_KEYEXP = 3'd7
  } op_e;
  localparam int unsigned NumLanes = 4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    logic [63:0] round_key_hi;
    logic [63:0] round_key_lo;
    logic [3:0]  round_index;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } out_item_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p = p ^ x;
      x = xtime(x);
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] x);
    logic [7:0] r;
    r = x;
    for (int k = 0; k < 6; k++) begin
      r = gf_mul(gf_mul(r, r), x);
    end
    return gf_mul(r, r);
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
    return 8'((b << n) | (b >> (8 - n)));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] b;
    b = gf_inv(x);
    return b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] inv_sbox_calc(input logic [7:0] y);
    return gf_inv(rotl8(y, 1) ^ rotl8(y, 3) ^ rotl8(y, 6) ^ 8'h05);
  endfunction

  typedef logic [7:0] sbox_tbl_t [256];

  function automatic sbox_tbl_t build_sbox(input logic inv);
    sbox_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inv ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
    end
    return t;
  endfunction

  localparam sbox_tbl_t SBOX = build_sbox(1'b0);
  localparam sbox_tbl_t INV_SBOX = build_sbox(1'b1);

  function automatic logic [7:0] rcon(input logic [3:0] ri);
    logic [7:0] r;
    case (ri)
      4'd0:  r = 8'h8d;
      4'd1:  r = 8'h01;
      4'd2:  r = 8'h02;
      4'd3:  r = 8'h04;
      4'd4:  r = 8'h08;
      4'd5:  r = 8'h10;
      4'd6:  r = 8'h20;
      4'd7:  r = 8'h40;
      4'd8:  r = 8'h80;
      4'd9:  r = 8'h1b;
      4'd10: r = 8'h36;
      4'd11: r = 8'h6c;
      4'd12: r = 8'hd8;
      4'd13: r = 8'hab;
      4'd14: r = 8'h4d;
      default: r = 8'h9a;
    endcase
    return r;
  endfunction
endpackage

// File: hdl/arpu_in_if.sv
interface arpu_in_if import arpu_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/arpu_out_if.sv
interface arpu_out_if import arpu_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/aes_round_primitive_unit.sv
// Results are registered in the output stage, or in the skid slot when
// the output stalls. Throughput: one item per cycle while the skid slot
// is empty; four column lanes plus a merge stage are combinational.
// Reset: rst_ni asynchronous active low clears the valid flags of both
// stages; payload registers are not reset.
`include "aes_round_primitive_unit_defines.svh"
module aes_round_primitive_unit import arpu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  arpu_in_if.sink    in_i,
  arpu_out_if.source out_o
);
  logic [127:0] blk;
  logic [127:0] key;
  logic [127:0] lanes;
  logic [127:0] res;
  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  out_item_t    out_q, out_d, skid_q, skid_d;
  logic         in_acc, out_acc;

  assign blk = {in_i.data.block_hi, in_i.data.block_lo};
  assign key = {in_i.data.round_key_hi, in_i.data.round_key_lo};

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    arpu_lane u_lane (
      .op_i  (in_i.data.operation),
      .col_i (blk[127-32*g -: 32]),
      .key_i (key[127-32*g -: 32]),
      .col_o (lanes[127-32*g -: 32])
    );
  end

  arpu_merge u_merge (
    .op_i          (in_i.data.operation),
    .blk_i         (blk),
    .lanes_i       (lanes),
    .round_index_i (in_i.data.round_index),
    .res_o         (res)
  );

  assign in_i.ready = !skid_valid_q;
  assign in_acc = in_i.valid && in_i.ready;
  assign out_acc = out_valid_q && out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d = out_q;
    skid_d = skid_q;
    if (out_acc || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d = skid_q;
        out_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d = res;
        out_valid_d = in_acc;
      end
    end else if (in_acc) begin
      skid_d = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data = out_q;

  `ARP_ASSERT(skid_implies_out, skid_valid_q |-> out_valid_q)
  `ARP_ASSERT(skid_holds_on_stall, (out_valid_q && !out_o.ready) |=> $stable(out_q))
  `ARP_ASSERT_RST(reset_clears, !rst_ni |=> (!out_valid_q && !skid_valid_q))
endmodule

// File: hdl/arpu_lane.sv
module arpu_lane import arpu_pkg::*; (
  input  logic [2:0]  op_i,
  input  logic [31:0] col_i,
  input  logic [31:0] key_i,
  output logic [31:0] col_o
);
  logic [7:0] a [4];
  logic [7:0] o [4];

  always_comb begin
    for (int r = 0; r < 4; r++) a[r] = col_i[31-8*r -: 8];
    for (int r = 0; r < 4; r++) o[r] = a[r];
    case (op_e'(op_i))
      OP_SUB: for (int r = 0; r < 4; r++) o[r] = SBOX[a[r]];
      OP_INVSUB: for (int r = 0; r < 4; r++) o[r] = INV_SBOX[a[r]];
      OP_ADDKEY: for (int r = 0; r < 4; r++) o[r] = a[r] ^ key_i[31-8*r -: 8];
      OP_MIX: for (int r = 0; r < 4; r++) begin
        o[r] = xtime(a[r]) ^ xtime(a[(r+1)%4]) ^ a[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
      end
      OP_INVMIX: for (int r = 0; r < 4; r++) begin
        o[r] = gf_mul(a[r], 8'h0e) ^ gf_mul(a[(r+1)%4], 8'h0b)
             ^ gf_mul(a[(r+2)%4], 8'h0d) ^ gf_mul(a[(r+3)%4], 8'h09);
      end
      default: ;
    endcase
    for (int r = 0; r < 4; r++) col_o[31-8*r -: 8] = o[r];
  end
endmodule

// File: hdl/arpu_merge.sv
module arpu_merge import arpu_pkg::*; (
  input  logic [2:0]   op_i,
  input  logic [127:0] blk_i,
  input  logic [127:0] lanes_i,
  input  logic [3:0]   round_index_i,
  output logic [127:0] res_o
);
  logic [7:0] b [16];
  logic [7:0] o [16];
  logic [7:0] t [4];

  always_comb begin
    for (int i = 0; i < 16; i++) b[i] = blk_i[127-8*i -: 8];
    t[0] = SBOX[b[13]] ^ rcon(round_index_i);
    t[1] = SBOX[b[14]];
    t[2] = SBOX[b[15]];
    t[3] = SBOX[b[12]];
    for (int i = 0; i < 16; i++) o[i] = 8'h00;
    res_o = lanes_i;
    case (op_e'(op_i))
      OP_SHIFT: begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) o[r+4*c] = b[r+4*((c+r)%4)];
        for (int i = 0; i < 16; i++) res_o[127-8*i -: 8] = o[i];
      end
      OP_INVSHIFT: begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) o[r+4*c] = b[r+4*((c+4-r)%4)];
        for (int i = 0; i < 16; i++) res_o[127-8*i -: 8] = o[i];
      end
      OP_KEYEXP: begin
        for (int i = 0; i < 4; i++) o[i] = b[i] ^ t[i];
        for (int i = 4; i < 16; i++) o[i] = b[i] ^ o[i-4];
        for (int i = 0; i < 16; i++) res_o[127-8*i -: 8] = o[i];
      end
      default: ;
    endcase
  end
endmodule

// File: bench/aes_round_primitive_unit_tb.sv
module aes_round_primitive_unit_tb;
  import arpu_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  arpu_in_if  in_bus ();
  arpu_out_if out_bus ();

  aes_round_primitive_unit DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #5 clk_i = ~clk_i;

  typedef struct {
    in_item_t  stim;
    logic      has_fixed;
    out_item_t fixed;
  } vector_t;

  out_item_t pending_results[$];
  int        error_count = 0;
  logic      stim_done = 1'b0;
  logic      hold_off = 1'b0;

  function automatic logic [7:0] mul_gf(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] inverse_gf(logic [7:0] x);
    logic [7:0] r;
    r = x;
    for (int k = 0; k < 6; k++) r = mul_gf(mul_gf(r, r), x);
    return mul_gf(r, r);
  endfunction

  function automatic logic [7:0] rot_byte(logic [7:0] b, int n);
    return (b << n) | (b >> (8 - n));
  endfunction

  function automatic logic [7:0] fwd_sub(logic [7:0] x);
    logic [7:0] b;
    b = inverse_gf(x);
    return b ^ rot_byte(b, 1) ^ rot_byte(b, 2) ^ rot_byte(b, 3) ^ rot_byte(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] rev_sub(logic [7:0] y);
    return inverse_gf(rot_byte(y, 1) ^ rot_byte(y, 3) ^ rot_byte(y, 6) ^ 8'h05);
  endfunction

  function automatic logic [7:0] round_const(logic [3:0] ri);
    logic [7:0] r;
    r = 8'h8d;
    for (int k = 0; k < ri; k++) r = mul_gf(r, 8'h02);
    return r;
  endfunction

  function automatic out_item_t transform_block(in_item_t s);
    logic [7:0] b [16];
    logic [7:0] k [16];
    logic [7:0] o [16];
    logic [7:0] t [4];
    logic [7:0] coef [4];
    logic [7:0] acc;
    out_item_t  res;
    for (int i = 0; i < 8; i++) begin
      b[i]     = s.block_hi[63 - 8 * i -: 8];
      b[8 + i] = s.block_lo[63 - 8 * i -: 8];
      k[i]     = s.round_key_hi[63 - 8 * i -: 8];
      k[8 + i] = s.round_key_lo[63 - 8 * i -: 8];
    end
    case (op_e'(s.operation))
      OP_SUB:    for (int i = 0; i < 16; i++) o[i] = fwd_sub(b[i]);
      OP_INVSUB: for (int i = 0; i < 16; i++) o[i] = rev_sub(b[i]);
      OP_ADDKEY: for (int i = 0; i < 16; i++) o[i] = b[i] ^ k[i];
      OP_SHIFT:
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) o[r + 4 * c] = b[r + 4 * ((c + r) & 3)];
      OP_INVSHIFT:
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) o[r + 4 * c] = b[r + 4 * ((c + 4 - r) & 3)];
      OP_MIX, OP_INVMIX: begin
        if (op_e'(s.operation) == OP_MIX) coef = '{8'h02, 8'h03, 8'h01, 8'h01};
        else coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) begin
            acc = 8'h00;
            for (int j = 0; j < 4; j++) acc ^= mul_gf(b[4 * c + j], coef[(j + 4 - r) & 3]);
            o[4 * c + r] = acc;
          end
      end
      default: begin
        t[0] = fwd_sub(b[13]) ^ round_const(s.round_index);
        t[1] = fwd_sub(b[14]);
        t[2] = fwd_sub(b[15]);
        t[3] = fwd_sub(b[12]);
        for (int i = 0; i < 4; i++) o[i] = b[i] ^ t[i];
        for (int i = 4; i < 16; i++) o[i] = b[i] ^ o[i - 4];
      end
    endcase
    for (int i = 0; i < 8; i++) begin
      res.result_hi[63 - 8 * i -: 8] = o[i];
      res.result_lo[63 - 8 * i -: 8] = o[8 + i];
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      default: v = {$urandom(), $urandom()};
    endcase
    return v;
  endfunction

  function automatic vector_t make_vec(op_e op, logic [63:0] bh, logic [63:0] bl,
                                       logic [63:0] kh, logic [63:0] kl, logic [3:0] ri,
                                       logic fx, logic [63:0] eh, logic [63:0] el);
    vector_t v;
    v.stim = '{operation: op, block_hi: bh, block_lo: bl, round_key_hi: kh,
               round_key_lo: kl, round_index: ri};
    v.has_fixed = fx;
    v.fixed = '{result_hi: eh, result_lo: el};
    return v;
  endfunction

  task automatic send_item(in_item_t s, int gap);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= s;
    pending_results.push_back(transform_block(s));
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  function automatic in_item_t random_item();
    in_item_t s;
    s.operation    = 3'($urandom_range(0, 7));
    s.block_hi     = rand64();
    s.block_lo     = rand64();
    s.round_key_hi = rand64();
    s.round_key_lo = rand64();
    s.round_index  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(1, 10));
    return s;
  endfunction

  vector_t directed[$];

  initial begin
    in_bus.valid  <= 1'b0;
    in_bus.data   <= '0;
    out_bus.ready <= 1'b0;
    directed.push_back(make_vec(OP_SUB, '0, '0, '0, '0, 4'd1, 1'b1,
                                64'h6363636363636363, 64'h6363636363636363));
    directed.push_back(make_vec(OP_SUB, '1, '1, '0, '0, 4'd1, 1'b1,
                                64'h1616161616161616, 64'h1616161616161616));
    directed.push_back(make_vec(OP_INVSUB, '0, '0, '1, '1, 4'd1, 1'b1,
                                64'h5252525252525252, 64'h5252525252525252));
    directed.push_back(make_vec(OP_ADDKEY, '1, '0, '1, '1, 4'd5, 1'b1, '0, '1));
    directed.push_back(make_vec(OP_SHIFT, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                                '1, '1, 4'd3, 1'b1, 64'h00050a0f04090e03, 64'h080d02070c01060b));
    directed.push_back(make_vec(OP_INVSHIFT, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                                '0, '0, 4'd3, 1'b1, 64'h000d0a0704010e0b, 64'h0805020f0c090603));
    directed.push_back(make_vec(OP_MIX, 64'hdb135345f20a225c, 64'h0101010101010101,
                                '0, '0, 4'd1, 1'b1, 64'h8e4da1bc9fdc589d, 64'h0101010101010101));
    directed.push_back(make_vec(OP_INVMIX, 64'h8e4da1bc9fdc589d, 64'h0101010101010101,
                                '1, '0, 4'd1, 1'b1, 64'hdb135345f20a225c, 64'h0101010101010101));
    directed.push_back(make_vec(OP_MIX, '1, '1, '0, '0, 4'd0, 1'b0, '0, '0));
    directed.push_back(make_vec(OP_INVMIX, '1, '1, '0, '0, 4'd0, 1'b0, '0, '0));
    directed.push_back(make_vec(OP_INVSUB, '1, '1, '0, '0, 4'd0, 1'b0, '0, '0));
    directed.push_back(make_vec(OP_KEYEXP, '0, '0, '1, '1, 4'd1, 1'b1,
                                64'h6263636362636363, 64'h6263636362636363));
    for (int ri = 0; ri < 16; ri++)
      directed.push_back(make_vec(OP_KEYEXP, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
                                  '0, '0, ri[3:0], 1'b0, '0, '0));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      if (directed[i].has_fixed && transform_block(directed[i].stim) != directed[i].fixed) begin
        $display("%0t predictor row %0d: expected %h actual %h", $time, i,
                 directed[i].fixed, transform_block(directed[i].stim));
        error_count++;
      end
      send_item(directed[i].stim, $urandom_range(0, 15));
    end
    for (int n = 0; n < 500; n++) begin
      if (n == 200) begin
        hold_off <= 1'b1;
        for (int j = 0; j < 12; j++) send_item(random_item(), 0);
      end else if (n % 100 > 80) begin
        send_item(random_item(), 0);
      end else begin
        send_item(random_item(), $urandom_range(0, 15));
      end
    end
    in_bus.valid <= 1'b0;
    stim_done <= 1'b1;
  end

  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      if (hold_off) begin
        out_bus.ready <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_off = 1'b0;
      end else begin
        gap = $urandom_range(0, 15);
        if (gap > 0) begin
          out_bus.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        out_bus.ready <= 1'b1;
        do @(posedge clk_i); while (!out_bus.valid);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected item: expected none actual %h", $time, out_bus.data);
        error_count++;
      end else begin
        if (out_bus.data.result_hi !== pending_results[0].result_hi) begin
          $display("%0t result_hi: expected %h actual %h", $time,
                   pending_results[0].result_hi, out_bus.data.result_hi);
          error_count++;
        end
        if (out_bus.data.result_lo !== pending_results[0].result_lo) begin
          $display("%0t result_lo: expected %h actual %h", $time,
                   pending_results[0].result_lo, out_bus.data.result_lo);
          error_count++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) $display("aes_round_primitive_unit regression: pass");
    else $display("aes_round_primitive_unit regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("aes_round_primitive_unit regression: fail");
    $finish;
  end
endmodule

// File: aes_round_primitive_unit.f
+incdir+hdl
hdl/arpu_pkg.sv
hdl/arpu_in_if.sv
hdl/arpu_out_if.sv
hdl/arpu_lane.sv
hdl/arpu_merge.sv
hdl/aes_round_primitive_unit.sv
bench/aes_round_primitive_unit_tb.sv
